>>> rtl/rge_pkg.sv
package rge_pkg;

	// Field widths fixed by the word format.
	localparam int SYM_W  = 13;
	localparam int IDX_W  = 12;
	localparam int BYTE_W = 8;

	// Width used for rule number arithmetic, wide enough for any table size.
	localparam int WIDE_W = 17;

	// Symbols up to LITERAL_MAX are bytes; rule numbers start at RULE_BASE.
	localparam logic [SYM_W-1:0]  LITERAL_MAX = 13'd255;
	localparam logic [WIDE_W-1:0] RULE_BASE   = 17'd256;

	typedef enum logic {
		OP_LOAD,
		OP_EXPAND
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_UNLOADED,
		ERR_OVERFLOW,
		ERR_TOO_LONG
	} err_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] rule_index;
		logic [SYM_W-1:0] left_symbol;
		logic [SYM_W-1:0] right_symbol;
		logic [SYM_W-1:0] code_symbol;
	} item_t;

	// Head of the queue as seen by the engine.
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// Engine status returned to the front end.
	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_LOOK,
		ST_POP,
		ST_ERR,
		ST_FIN
	} state_t;

endpackage

>>> rtl/rge_front.sv
module rge_front #(
	parameter int NUM_RULES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [rge_pkg::IDX_W-1:0]   rule_index,
	input  logic [rge_pkg::SYM_W-1:0]   left_symbol,
	input  logic [rge_pkg::SYM_W-1:0]   right_symbol,
	input  logic [rge_pkg::SYM_W-1:0]   code_symbol,
	input  rge_pkg::back_stat_t         stat,
	output rge_pkg::head_t              head
);

	localparam int DEPTH = 2;

	rge_pkg::item_t              entry_q [DEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  count_q;
	logic                        accept;
	logic                        in_range;
	logic                        push;
	rge_pkg::item_t              new_item;

	assign busy     = stat.clearing || (count_q == 2'(DEPTH));
	assign accept   = start && !busy;
	assign in_range = rge_pkg::WIDE_W'(rule_index) < rge_pkg::WIDE_W'(NUM_RULES);

	// A load aimed beyond the table is dropped here and never queued.
	assign push = accept &&
		!((rge_pkg::op_t'(operation) == rge_pkg::OP_LOAD) && !in_range);

	always_comb begin
		new_item.op           = rge_pkg::op_t'(operation);
		new_item.rule_index   = rule_index;
		new_item.left_symbol  = left_symbol;
		new_item.right_symbol = right_symbol;
		new_item.code_symbol  = code_symbol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (stat.pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !stat.pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && stat.pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

endmodule

>>> rtl/rge_back.sv
module rge_back #(
	parameter int NUM_RULES = 4096,
	parameter int MAX_DEPTH = 32,
	parameter int MAX_OUT   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rge_pkg::head_t              head,
	output rge_pkg::back_stat_t         stat,
	output logic                        out_valid,
	output logic [rge_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last,
	output logic [1:0]                  error
);

	localparam int AW   = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int SA_W = $clog2(MAX_DEPTH);
	localparam int SP_W = $clog2(MAX_DEPTH + 1);
	localparam int N_W  = $clog2(MAX_OUT + 1);
	localparam int SYM_W = rge_pkg::SYM_W;
	localparam int BYTE_W = rge_pkg::BYTE_W;
	localparam int WIDE_W = rge_pkg::WIDE_W;

	// Rule pair store, loaded flags and the expansion stack.
	logic [2*SYM_W-1:0] pair_mem [NUM_RULES];
	logic               flag_mem [NUM_RULES];
	logic [SYM_W-1:0]   stk_mem  [MAX_DEPTH];
	logic [2*SYM_W-1:0] pair_rd_q;
	logic               flag_rd_q;
	logic [SYM_W-1:0]   stk_rd_q;

	rge_pkg::state_t    state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [SYM_W-1:0]   cur_q;
	logic [SP_W-1:0]    sp_q;
	logic [N_W-1:0]     n_q;
	logic               pend_v_q;
	logic [BYTE_W-1:0]  pend_q;
	rge_pkg::err_t      err_q;
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               last_q;
	rge_pkg::err_t      error_q;

	logic [WIDE_W-1:0]  rule_w;
	logic [WIDE_W-1:0]  load_w;
	logic [AW-1:0]      rule_addr;
	logic [AW-1:0]      load_addr;
	logic               is_lit;
	logic               rule_in_range;
	logic               n_full;
	logic               depth_ok;
	logic [SP_W-1:0]    stk_raddr_w;
	logic [SA_W-1:0]    stk_raddr;

	logic               q_pop;
	logic               emit;
	logic [BYTE_W-1:0]  emit_byte;
	logic               emit_last;
	rge_pkg::err_t      emit_err;
	logic               fail;
	rge_pkg::err_t      fail_code;
	logic               start_exp;
	logic               pend_set;
	logic               sp_inc;
	logic               sp_dec;
	logic               stk_we;
	logic               cur_from_left;
	logic               cur_from_stack;
	logic               pmem_we;
	logic               fmem_we;
	logic               fmem_wdata;
	logic [AW-1:0]      fmem_waddr;
	logic               clr_inc;

	assign is_lit        = (cur_q <= rge_pkg::LITERAL_MAX);
	assign rule_w        = WIDE_W'(cur_q) - rge_pkg::RULE_BASE;
	assign rule_in_range = rule_w < WIDE_W'(NUM_RULES);
	assign rule_addr     = rule_w[AW-1:0];
	assign load_w        = WIDE_W'(head.item.rule_index);
	assign load_addr     = load_w[AW-1:0];
	assign n_full        = (n_q >= N_W'(MAX_OUT));
	assign depth_ok      = ((SP_W+1)'(sp_q) + (SP_W+1)'(2)) <= (SP_W+1)'(MAX_DEPTH);
	assign stk_raddr_w   = sp_q - SP_W'(1);
	assign stk_raddr     = stk_raddr_w[SA_W-1:0];

	always_comb begin
		state_d        = state_q;
		q_pop          = 1'b0;
		emit           = 1'b0;
		emit_byte      = pend_q;
		emit_last      = 1'b0;
		emit_err       = rge_pkg::ERR_NONE;
		fail           = 1'b0;
		fail_code      = rge_pkg::ERR_NONE;
		start_exp      = 1'b0;
		pend_set       = 1'b0;
		sp_inc         = 1'b0;
		sp_dec         = 1'b0;
		stk_we         = 1'b0;
		cur_from_left  = 1'b0;
		cur_from_stack = 1'b0;
		pmem_we        = 1'b0;
		fmem_we        = 1'b0;
		fmem_wdata     = 1'b0;
		fmem_waddr     = load_addr;
		clr_inc        = 1'b0;

		unique case (state_q)
			rge_pkg::ST_CLEAR: begin
				fmem_we    = 1'b1;
				fmem_waddr = clr_q;
				if (clr_q == AW'(NUM_RULES - 1)) begin
					state_d = rge_pkg::ST_IDLE;
				end else begin
					clr_inc = 1'b1;
				end
			end
			rge_pkg::ST_IDLE: begin
				if (head.valid) begin
					q_pop = 1'b1;
					if (head.item.op == rge_pkg::OP_LOAD) begin
						pmem_we    = 1'b1;
						fmem_we    = 1'b1;
						fmem_wdata = 1'b1;
					end else begin
						start_exp = 1'b1;
						state_d   = rge_pkg::ST_EXEC;
					end
				end
			end
			rge_pkg::ST_EXEC: begin
				if (is_lit) begin
					if (n_full) begin
						fail      = 1'b1;
						fail_code = rge_pkg::ERR_TOO_LONG;
					end else begin
						emit     = pend_v_q;
						pend_set = 1'b1;
						if (sp_q == '0) begin
							state_d = rge_pkg::ST_FIN;
						end else begin
							sp_dec  = 1'b1;
							state_d = rge_pkg::ST_POP;
						end
					end
				end else if (!rule_in_range) begin
					fail      = 1'b1;
					fail_code = rge_pkg::ERR_UNLOADED;
				end else begin
					state_d = rge_pkg::ST_LOOK;
				end
			end
			rge_pkg::ST_LOOK: begin
				if (!flag_rd_q) begin
					fail      = 1'b1;
					fail_code = rge_pkg::ERR_UNLOADED;
				end else if (!depth_ok) begin
					fail      = 1'b1;
					fail_code = rge_pkg::ERR_OVERFLOW;
				end else begin
					stk_we        = 1'b1;
					sp_inc        = 1'b1;
					cur_from_left = 1'b1;
					state_d       = rge_pkg::ST_EXEC;
				end
			end
			rge_pkg::ST_POP: begin
				cur_from_stack = 1'b1;
				state_d        = rge_pkg::ST_EXEC;
			end
			rge_pkg::ST_ERR: begin
				emit      = 1'b1;
				emit_byte = '0;
				emit_last = 1'b1;
				emit_err  = err_q;
				state_d   = rge_pkg::ST_IDLE;
			end
			rge_pkg::ST_FIN: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				state_d   = rge_pkg::ST_IDLE;
			end
			default: begin
				state_d = rge_pkg::ST_IDLE;
			end
		endcase

		// On an error the held byte goes out now, unless the error result
		// has to take its place because the output count is already full.
		if (fail) begin
			emit    = pend_v_q && !n_full;
			state_d = rge_pkg::ST_ERR;
		end
	end

	assign stat.pop      = q_pop;
	assign stat.clearing = (state_q == rge_pkg::ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rge_pkg::ST_CLEAR;
			clr_q       <= '0;
			sp_q        <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= emit;
			if (clr_inc) begin
				clr_q <= clr_q + AW'(1);
			end
			if (start_exp) begin
				sp_q     <= '0;
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end else begin
				if (sp_inc) begin
					sp_q <= sp_q + SP_W'(1);
				end else if (sp_dec) begin
					sp_q <= sp_q - SP_W'(1);
				end
				if (pend_set) begin
					n_q      <= n_q + N_W'(1);
					pend_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_exp) begin
			cur_q <= head.item.code_symbol;
		end else if (cur_from_left) begin
			cur_q <= pair_rd_q[2*SYM_W-1:SYM_W];
		end else if (cur_from_stack) begin
			cur_q <= stk_rd_q;
		end
		if (pend_set) begin
			pend_q <= cur_q[BYTE_W-1:0];
		end
		if (fail) begin
			err_q <= fail_code;
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			error_q    <= emit_err;
		end
	end

	// Rule store: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (pmem_we) begin
			pair_mem[load_addr] <= {head.item.left_symbol, head.item.right_symbol};
		end
		pair_rd_q <= pair_mem[rule_addr];
	end

	always_ff @(posedge clk) begin
		if (fmem_we) begin
			flag_mem[fmem_waddr] <= fmem_wdata;
		end
		flag_rd_q <= flag_mem[rule_addr];
	end

	// Stack below the current symbol; the read is always of the top entry.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[sp_q[SA_W-1:0]] <= pair_rd_q[SYM_W-1:0];
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

>>> rtl/repair_grammar_expander.sv
// Re-Pair grammar expander: loads rule pairs and expands compressed symbols.
//
// Input words are offered on start and taken at a rising edge where start is
// high and busy is low. operation selects a load, which writes left_symbol and
// right_symbol into slot rule_index, or an expansion of code_symbol. Loads
// beyond NUM_RULES are dropped silently and give no result.
// Accepted words wait in a two-entry queue; the expansion engine behind it
// takes them in order; busy is high only while it is full or the flags clear.
// Results leave one word at a time with out_valid high for exactly one cycle;
// the receiver cannot hold them off, so nothing here ever waits on it.
// When the engine is free, a literal symbol goes from the queue head through
// the idle, execute and finish states to the output register. Inside an
// expansion a rule step passes through a lookup state, which reads the pair
// and its loaded flag, and a byte step with symbols left on the stack through
// a pop state, which reads the next one; both memories have registered reads.
// A load is written from the idle state, which the engine does not leave.
// After reset the loaded flags are cleared by a pass over all NUM_RULES slots,
// during which busy stays high; the rule pairs themselves are not cleared.
module repair_grammar_expander #(
	parameter int NUM_RULES = 4096,
	parameter int MAX_DEPTH = 32,
	parameter int MAX_OUT   = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [rge_pkg::IDX_W-1:0]   rule_index,
	input  logic [rge_pkg::SYM_W-1:0]   left_symbol,
	input  logic [rge_pkg::SYM_W-1:0]   right_symbol,
	input  logic [rge_pkg::SYM_W-1:0]   code_symbol,
	output logic                        out_valid,
	output logic [rge_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last,
	output logic [1:0]                  error
);

	// Queue head handed to the engine, and the engine's pop and clear status.
	rge_pkg::head_t      head;
	rge_pkg::back_stat_t stat;

	// The front end takes words, drops out-of-range loads and queues the rest.
	rge_front #(
		.NUM_RULES (NUM_RULES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.rule_index   (rule_index),
		.left_symbol  (left_symbol),
		.right_symbol (right_symbol),
		.code_symbol  (code_symbol),
		.stat         (stat),
		.head         (head)
	);

	// The engine owns the rule memories and the stack, walks each expansion
	// depth first and holds one byte back so that the final one carries last.
	rge_back #(
		.NUM_RULES (NUM_RULES),
		.MAX_DEPTH (MAX_DEPTH),
		.MAX_OUT   (MAX_OUT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error)
	);

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Block sizes under test; they are passed to the instance so that the
	// prediction below and the hardware agree on every bound.
	localparam int NUM_RULES = 4096;
	localparam int MAX_DEPTH = 32;
	localparam int MAX_OUT   = 64;

	// The slowest correct run stays below this: the flag-clearing pass after
	// reset, then fewer than two hundred words. Each word produces at most
	// MAX_OUT bytes, plus the sender's longest gap.
	localparam int CYCLE_LIMIT = 300000;

	// Cycles allowed after the last expected byte for any stray output word.
	localparam int TAIL_CYCLES = 400;

	// One decoded output word as the block should present it.
	typedef struct {
		logic [rge_pkg::BYTE_W-1:0] value;
		logic                       fin;
		rge_pkg::err_t              code;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic operation;
	logic [rge_pkg::IDX_W-1:0]  rule_index;
	logic [rge_pkg::SYM_W-1:0]  left_symbol;
	logic [rge_pkg::SYM_W-1:0]  right_symbol;
	logic [rge_pkg::SYM_W-1:0]  code_symbol;
	logic                       out_valid;
	logic [rge_pkg::BYTE_W-1:0] out_byte;
	logic                       last;
	logic [1:0]                 error;

	// Our own copy of the rule table. Entries of rule_lhs and rule_rhs are
	// only looked at where rule_defined is set, exactly as in the hardware.
	logic [rge_pkg::SYM_W-1:0] rule_lhs [NUM_RULES];
	logic [rge_pkg::SYM_W-1:0] rule_rhs [NUM_RULES];
	bit                        rule_defined [NUM_RULES];

	// Bytes predicted but not yet seen on the output, oldest first.
	decoded_t decoded_queue [$];

	// Slots that the random grammar generator may refer to as children.
	int grammar_slots [$];

	int gap_pct = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int expands_sent = 0;
	int words_checked = 0;
	int failures = 0;
	int faults_predicted [4];
	int cycle_count = 0;

	repair_grammar_expander #(
		.NUM_RULES (NUM_RULES),
		.MAX_DEPTH (MAX_DEPTH),
		.MAX_OUT   (MAX_OUT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.rule_index   (rule_index),
		.left_symbol  (left_symbol),
		.right_symbol (right_symbol),
		.code_symbol  (code_symbol),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a missing byte ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d bytes still expected", $realtime,
				decoded_queue.size());
			$display("[repair_grammar_expander] ERROR");
			$finish;
		end
	end

	// A load writes the pair and marks the slot; it produces no output word.
	function automatic void store_rule(input logic [rge_pkg::IDX_W-1:0] idx,
			input logic [rge_pkg::SYM_W-1:0] lhs, input logic [rge_pkg::SYM_W-1:0] rhs);
		if (int'(idx) < NUM_RULES) begin
			rule_lhs[idx] = lhs;
			rule_rhs[idx] = rhs;
			rule_defined[idx] = 1'b1;
		end
	endfunction

	// Depth-first expansion of one code symbol, left child before right,
	// with the same bounded stack and byte budget as the hardware. The
	// predicted bytes are appended to decoded_queue.
	function automatic void expand_symbol(input logic [rge_pkg::SYM_W-1:0] code);
		logic [rge_pkg::SYM_W-1:0] pending [$];
		decoded_t                  words [$];
		decoded_t                  word;
		logic [rge_pkg::SYM_W-1:0] sym;
		int                        rule;
		rge_pkg::err_t             fault;

		fault = rge_pkg::ERR_NONE;
		pending.insert(pending.size(), code);
		while (pending.size() != 0) begin
			sym = pending.pop_back();
			if (sym <= rge_pkg::LITERAL_MAX) begin
				// A byte beyond the budget aborts the expansion.
				if (words.size() >= MAX_OUT) begin
					fault = rge_pkg::ERR_TOO_LONG;
					break;
				end
				word.value = sym[rge_pkg::BYTE_W-1:0];
				word.fin   = 1'b0;
				word.code  = rge_pkg::ERR_NONE;
				words.insert(words.size(), word);
				continue;
			end
			rule = int'(sym) - int'(rge_pkg::RULE_BASE);
			if (rule >= NUM_RULES || !rule_defined[rule]) begin
				fault = rge_pkg::ERR_UNLOADED;
				break;
			end
			if (pending.size() + 2 > MAX_DEPTH) begin
				fault = rge_pkg::ERR_OVERFLOW;
				break;
			end
			// Right goes in first so that the left child is popped next.
			pending.insert(pending.size(), rule_rhs[rule]);
			pending.insert(pending.size(), rule_lhs[rule]);
		end

		if (fault != rge_pkg::ERR_NONE) begin
			// The error word takes the place of the final byte when the
			// budget is already used up, so the count never exceeds MAX_OUT.
			if (words.size() >= MAX_OUT)
				void'(words.pop_back());
			word.value = '0;
			word.fin   = 1'b1;
			word.code  = fault;
			words.insert(words.size(), word);
		end else if (words.size() != 0) begin
			words[words.size()-1].fin = 1'b1;
		end
		faults_predicted[fault]++;
		foreach (words[i])
			decoded_queue.insert(decoded_queue.size(), words[i]);
	endfunction

	// Offers one word and waits for the block to take it. A random idle
	// stretch may precede the offer. start is left high on return, so that a
	// following call can present the next word at once without a dip.
	task automatic send_word(input rge_pkg::op_t op, input logic [rge_pkg::IDX_W-1:0] idx,
			input logic [rge_pkg::SYM_W-1:0] lhs, input logic [rge_pkg::SYM_W-1:0] rhs,
			input logic [rge_pkg::SYM_W-1:0] code);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start        <= 1'b1;
		operation    <= op;
		rule_index   <= idx;
		left_symbol  <= lhs;
		right_symbol <= rhs;
		code_symbol  <= code;
		// busy as read here is its value before this edge, which is the one
		// that decides whether the word was taken at this edge.
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		if (op == rge_pkg::OP_LOAD) begin
			loads_sent++;
			store_rule(idx, lhs, rhs);
		end else begin
			expands_sent++;
			expand_symbol(code);
		end
	endtask

	// The fields that an operation does not use carry random values, so that
	// the block is seen to ignore them.
	task automatic load_word(input int idx, input logic [rge_pkg::SYM_W-1:0] lhs,
			input logic [rge_pkg::SYM_W-1:0] rhs);
		send_word(rge_pkg::OP_LOAD, rge_pkg::IDX_W'(idx), lhs, rhs,
			rge_pkg::SYM_W'($urandom_range(8191)));
	endtask

	task automatic expand_word(input logic [rge_pkg::SYM_W-1:0] code);
		send_word(rge_pkg::OP_EXPAND, rge_pkg::IDX_W'($urandom_range(4095)),
			rge_pkg::SYM_W'($urandom_range(8191)), rge_pkg::SYM_W'($urandom_range(8191)),
			code);
	endtask

	// Every output word is compared with the oldest prediction. The receiver
	// cannot push back, so a word is taken whenever out_valid is high.
	always @(posedge clk) begin : check_output
		decoded_t want;
		if (arst_n && out_valid) begin
			if (decoded_queue.size() == 0) begin
				$display("%0t: output word with nothing expected: byte %02h last %b error %0d",
					$realtime, out_byte, last, error);
				failures++;
			end else begin
				want = decoded_queue.pop_front();
				words_checked++;
				if (out_byte !== want.value) begin
					$display("%0t: out_byte expected %02h, got %02h",
						$realtime, want.value, out_byte);
					failures++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %b, got %b", $realtime, want.fin, last);
					failures++;
				end
				if (error !== want.code) begin
					$display("%0t: error expected %0d, got %0d",
						$realtime, want.code, error);
					failures++;
				end
			end
		end
	end

	// Literal codes at both ends of the byte range and checkerboard patterns,
	// then codes naming a rule that was never loaded and one that lies beyond
	// the table altogether.
	task automatic test_literal_codes();
		expand_word(13'd0);
		expand_word(13'd255);
		expand_word(13'h055);
		expand_word(13'h0AA);
		expand_word(13'd256);
		expand_word(13'd8191);
	endtask

	// A doubling chain in slots 0 to 6. Slot 5 expands to exactly the byte
	// budget and must finish cleanly; slot 6 needs twice as many and must end
	// with the too-long error replacing the final byte.
	task automatic test_doubling_chain();
		load_word(0, 13'h041, 13'h042);
		for (int k = 1; k <= 6; k++)
			load_word(k, rge_pkg::SYM_W'(256 + k - 1), rge_pkg::SYM_W'(256 + k - 1));
		expand_word(rge_pkg::SYM_W'(256 + 5));
		expand_word(rge_pkg::SYM_W'(256 + 6));
	endtask

	// Cyclic grammars. A rule made of itself twice grows the stack by one on
	// every step until it overflows. A rule with itself on the right emits one
	// byte per step and keeps running until the byte budget stops it. The top
	// slot is used so that the widest index and symbol are exercised.
	task automatic test_cyclic_rules();
		load_word(4095, 13'd4351, 13'd4351);
		expand_word(13'd4351);
		load_word(20, 13'h061, rge_pkg::SYM_W'(256 + 20));
		expand_word(rge_pkg::SYM_W'(256 + 20));
		// Overwriting the slot must remove the cycle.
		load_word(20, 13'h062, 13'h063);
		expand_word(rge_pkg::SYM_W'(256 + 20));
	endtask

	// Bytes produced before a fault are kept with last low, followed by the
	// error word. Also a rule whose left child points beyond the table.
	task automatic test_partial_then_error();
		load_word(21, 13'h010, rge_pkg::SYM_W'(256 + 3000));
		expand_word(rge_pkg::SYM_W'(256 + 21));
		load_word(22, 13'd8191, 13'd0);
		expand_word(rge_pkg::SYM_W'(256 + 22));
	endtask

	// A child for a new rule: mostly a literal or a rule already built, now
	// and then any symbol at all, which may be unloaded or out of range.
	function automatic logic [rge_pkg::SYM_W-1:0] pick_child();
		int roll;
		roll = $urandom_range(99);
		if (grammar_slots.size() == 0 || roll < 45)
			return rge_pkg::SYM_W'($urandom_range(255));
		if (roll < 95)
			return rge_pkg::SYM_W'(256 +
				grammar_slots[$urandom_range(grammar_slots.size() - 1)]);
		return rge_pkg::SYM_W'($urandom_range(8191));
	endfunction

	// A code to expand: usually the newest rule, which tends to be the
	// deepest, otherwise an older rule, a literal or an arbitrary symbol.
	function automatic logic [rge_pkg::SYM_W-1:0] pick_code();
		int roll;
		roll = $urandom_range(99);
		if (grammar_slots.size() != 0 && roll < 50)
			return rge_pkg::SYM_W'(256 + grammar_slots[grammar_slots.size() - 1]);
		if (grammar_slots.size() != 0 && roll < 75)
			return rge_pkg::SYM_W'(256 +
				grammar_slots[$urandom_range(grammar_slots.size() - 1)]);
		if (roll < 88)
			return rge_pkg::SYM_W'($urandom_range(255));
		return rge_pkg::SYM_W'($urandom_range(8191));
	endfunction

	// Random grammars: a few rules built bottom up into random slots, then a
	// few expansions over them. About one in ten of the rule words is pure
	// noise with every field random. Half the time a new grammar starts from
	// nothing, otherwise it grows on the old one, which drives the deeper rules
	// into the stack and byte limits.
	task automatic test_random_grammars(input int idle_pct, input int word_count);
		int target;
		int slot;
		gap_pct = idle_pct;
		target = items_sent + word_count;
		while (items_sent < target) begin
			if ($urandom_range(1) == 0)
				grammar_slots.delete();
			repeat ($urandom_range(2, 6)) begin
				if ($urandom_range(99) < 10) begin
					send_word(rge_pkg::op_t'($urandom_range(1)),
						rge_pkg::IDX_W'($urandom_range(4095)),
						rge_pkg::SYM_W'($urandom_range(8191)),
						rge_pkg::SYM_W'($urandom_range(8191)),
						rge_pkg::SYM_W'($urandom_range(8191)));
				end else begin
					slot = $urandom_range(NUM_RULES - 1);
					load_word(slot, pick_child(), pick_child());
					grammar_slots.insert(grammar_slots.size(), slot);
				end
			end
			repeat ($urandom_range(2, 5))
				expand_word(pick_code());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = rge_pkg::OP_LOAD;
		rule_index   = '0;
		left_symbol  = '0;
		right_symbol = '0;
		code_symbol  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed tests run without gaps; busy stays high during the
		// flag-clearing pass, which the first handshake simply waits out.
		test_literal_codes();
		test_doubling_chain();
		test_cyclic_rules();
		test_partial_then_error();

		// Random phases: back to back, then a sender that idles often, then
		// a lighter mix. The receiver cannot hold results off, so there is no
		// stalling phase on that side.
		test_random_grammars(0, 30);
		test_random_grammars(45, 30);
		test_random_grammars(25, 30);

		start <= 1'b0;
		while (decoded_queue.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d rule loads and %0d expansions; %0d output words checked.",
			loads_sent, expands_sent, words_checked);
		$display("Expansions ending clean/unloaded/overflow/too long: %0d/%0d/%0d/%0d.",
			faults_predicted[rge_pkg::ERR_NONE], faults_predicted[rge_pkg::ERR_UNLOADED],
			faults_predicted[rge_pkg::ERR_OVERFLOW], faults_predicted[rge_pkg::ERR_TOO_LONG]);
		if (failures == 0) begin
			$display("[repair_grammar_expander] OK");
		end else begin
			$display("%0d mismatches", failures);
			$display("[repair_grammar_expander] ERROR");
		end
		$finish;
	end

endmodule

>>> repair_grammar_expander.f
rtl/rge_pkg.sv
rtl/rge_front.sv
rtl/rge_back.sv
rtl/repair_grammar_expander.sv
bench/tb_top.sv
